[rtl/core/cmm_pkg.sv]
package cmm_pkg;

  localparam int MAX_ROWS_DEF        = 32;
  localparam int MAX_COLS_DEF        = 32;
  localparam int MAX_CHANNELS_DEF    = 8;
  localparam int MAX_KERNELS_DEF     = 8;
  localparam int MAX_KERNEL_SIZE_DEF = 7;

  localparam int IDX_W   = 13;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 6;
  localparam int CFGA_W  = 3;
  localparam int S_DATA_W = 48;
  localparam int S_USER_W = 4;
  localparam int M_DATA_W = 40;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_RUN   = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SEL_IMAGE  = 2'd0,
    SEL_KERNEL = 2'd1,
    SEL_OUTPUT = 2'd2,
    SEL_NONE   = 2'd3
  } sel_t;

  typedef enum logic [1:0] {
    MODE_FWD   = 2'd0,
    MODE_IGRAD = 2'd1,
    MODE_KGRAD = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [CFGA_W-1:0] CFG_ROWS     = 3'd0;
  localparam logic [CFGA_W-1:0] CFG_COLS     = 3'd1;
  localparam logic [CFGA_W-1:0] CFG_CHANNELS = 3'd2;
  localparam logic [CFGA_W-1:0] CFG_KCOUNT   = 3'd3;
  localparam logic [CFGA_W-1:0] CFG_KROWS    = 3'd4;
  localparam logic [CFGA_W-1:0] CFG_KCOLS    = 3'd5;
  localparam logic [CFGA_W-1:0] CFG_MODE     = 3'd6;

  typedef enum logic [8:0] {
    S_IDLE = 9'b0_0000_0001,
    S_HRD  = 9'b0_0000_0010,
    S_HOUT = 9'b0_0000_0100,
    S_P0   = 9'b0_0000_1000,
    S_P1   = 9'b0_0001_0000,
    S_P2   = 9'b0_0010_0000,
    S_RD   = 9'b0_0100_0000,
    S_ACC  = 9'b0_1000_0000,
    S_MUL  = 9'b1_0000_0000
  } state_t;

  typedef struct packed {
    logic clr;
    logic inc;
  } cell_ctl_t;

endpackage

[rtl/core/cmm_ctr_cell.sv]
module cmm_ctr_cell #(
  parameter int W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  cmm_pkg::cell_ctl_t  ctl,
  input  logic [W-1:0]        lim,
  output logic [W-1:0]        val,
  output logic                carry
);
  import cmm_pkg::*;

  logic wrap;

  assign wrap  = (val == lim - W'(1));
  assign carry = ctl.inc && wrap;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      val <= '0;
    end else if (ctl.inc) begin
      val <= wrap ? '0 : val + W'(1);
    end
  end

endmodule

[rtl/core/cmm_mac.sv]
module cmm_mac (
  input  logic                          clk,
  input  logic signed [cmm_pkg::VAL_W-1:0] a,
  input  logic signed [cmm_pkg::VAL_W-1:0] b,
  input  logic signed [cmm_pkg::VAL_W-1:0] acc,
  output logic signed [cmm_pkg::VAL_W-1:0] sum,
  output logic                          ovf
);
  import cmm_pkg::*;

  logic signed [2*VAL_W-1:0] prod;
  logic signed [2*VAL_W-17:0] q;
  logic signed [2*VAL_W-16:0] s;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // floor(p / 2^16)
  assign q = prod[2*VAL_W-1:16];
  assign s = (2*VAL_W-15)'(acc) + (2*VAL_W-15)'(q);

  always_comb begin
    ovf = 1'b0;
    sum = s[VAL_W-1:0];
    if (s > (2*VAL_W-15)'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
      sum = {1'b0, {(VAL_W-1){1'b1}}};
      ovf = 1'b1;
    end else if (s < (2*VAL_W-15)'(signed'({1'b1, {(VAL_W-1){1'b0}}}))) begin
      sum = {1'b1, {(VAL_W-1){1'b0}}};
      ovf = 1'b1;
    end
  end

endmodule

[rtl/core/conv2d_multichannel_mac.sv]
// Writes, rejected items and runs that do nothing: result in the cycle after the beat.
// Reads: the result passes states S_HRD and S_HOUT after the beat (registered store read).
// A run walks rows*cols*kernels*krows*kcols*channels taps via a chain of six loop counter
// cells: one tap per cycle outside the image; in it, S_P0, S_P1, S_P2, S_RD, S_MUL, S_ACC.
// One item at a time; a beat is taken once the result has left and cfg_wait has run down.
// rst (synchronous) restores register defaults; store contents are not cleared.
module conv2d_multichannel_mac #(
  parameter int MAX_ROWS        = cmm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS        = cmm_pkg::MAX_COLS_DEF,
  parameter int MAX_CHANNELS    = cmm_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_KERNELS     = cmm_pkg::MAX_KERNELS_DEF,
  parameter int MAX_KERNEL_SIZE = cmm_pkg::MAX_KERNEL_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [cmm_pkg::CFGA_W-1:0]    cfg_addr,
  input  logic [cmm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cmm_pkg::S_DATA_W-1:0]  s_axis_tdata,  // element_index, write_value
  input  logic [cmm_pkg::S_USER_W-1:0]  s_axis_tuser,  // req_type, store_select
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cmm_pkg::M_DATA_W-1:0]  m_axis_tdata   // read_value, status, saturated
);
  import cmm_pkg::*;

  localparam int DMAX1 = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DMAX2 = (MAX_CHANNELS > MAX_KERNELS) ? MAX_CHANNELS : MAX_KERNELS;
  localparam int DMAX3 = (DMAX1 > DMAX2) ? DMAX1 : DMAX2;
  localparam int DMAX  = (DMAX3 > MAX_KERNEL_SIZE) ? DMAX3 : MAX_KERNEL_SIZE;
  localparam int CW    = $clog2(DMAX + 1);
  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
  localparam int OUT_DEPTH = MAX_ROWS * MAX_COLS * MAX_KERNELS;
  localparam int KER_DEPTH = MAX_KERNELS * MAX_KERNEL_SIZE * MAX_KERNEL_SIZE * MAX_CHANNELS;
  localparam int IAW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int OAW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int KAW = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
  localparam int ISW = $clog2(IMG_DEPTH + 1);
  localparam int OSW = $clog2(OUT_DEPTH + 1);
  localparam int KSW = $clog2(KER_DEPTH + 1);
  localparam int NCELL = 6;

  // config registers
  logic [5:0] image_rows, image_cols;
  logic [3:0] image_channels, kernel_count;
  logic [2:0] kernel_rows, kernel_cols;
  logic [1:0] mac_mode;
  logic [1:0] cfg_wait;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows     <= 6'd32;
      image_cols     <= 6'd32;
      image_channels <= 4'd1;
      kernel_count   <= 4'd1;
      kernel_rows    <= 3'd3;
      kernel_cols    <= 3'd3;
      mac_mode       <= MODE_FWD;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_ROWS:     image_rows     <= cfg_wdata[5:0];
        CFG_COLS:     image_cols     <= cfg_wdata[5:0];
        CFG_CHANNELS: image_channels <= cfg_wdata[3:0];
        CFG_KCOUNT:   kernel_count   <= cfg_wdata[3:0];
        CFG_KROWS:    kernel_rows    <= cfg_wdata[2:0];
        CFG_KCOLS:    kernel_cols    <= cfg_wdata[2:0];
        CFG_MODE:     mac_mode       <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // hold off beats until the size pipeline has settled
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      cfg_wait <= 2'd3;
    end else if (cfg_wait != '0) begin
      cfg_wait <= cfg_wait - 2'd1;
    end
  end

  // effective dimensions
  logic [CW-1:0] r_eff, c_eff, ch_eff, k_eff, kr_c, kc_c, kr_eff, kc_eff, hr, hc;

  assign r_eff  = (32'(image_rows) > 32'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(image_rows);
  assign c_eff  = (32'(image_cols) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(image_cols);
  assign ch_eff = (32'(image_channels) > 32'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS)
                                                            : CW'(image_channels);
  assign k_eff  = (32'(kernel_count) > 32'(MAX_KERNELS)) ? CW'(MAX_KERNELS)
                                                         : CW'(kernel_count);
  assign kr_c   = (32'(kernel_rows) > 32'(MAX_KERNEL_SIZE)) ? CW'(MAX_KERNEL_SIZE)
                                                            : CW'(kernel_rows);
  assign kc_c   = (32'(kernel_cols) > 32'(MAX_KERNEL_SIZE)) ? CW'(MAX_KERNEL_SIZE)
                                                            : CW'(kernel_cols);
  assign kr_eff = (kr_c != '0 && !kr_c[0]) ? kr_c - CW'(1) : kr_c;
  assign kc_eff = (kc_c != '0 && !kc_c[0]) ? kc_c - CW'(1) : kc_c;
  assign hr     = kr_eff >> 1;
  assign hc     = kc_eff >> 1;

  // tensor sizes, pipelined after each config write
  logic [ISW-1:0] rc_i, img_size;
  logic [OSW-1:0] rc_o, out_size;
  logic [KSW-1:0] kk, kkc, ker_size;

  always_ff @(posedge clk) begin
    rc_i     <= ISW'(r_eff) * ISW'(c_eff);
    img_size <= rc_i * ISW'(ch_eff);
    rc_o     <= OSW'(r_eff) * OSW'(c_eff);
    out_size <= rc_o * OSW'(k_eff);
    kk       <= KSW'(kr_eff) * KSW'(kc_eff);
    kkc      <= kk * KSW'(ch_eff);
    ker_size <= kkc * KSW'(k_eff);
  end

  // input beat fields
  logic [IDX_W-1:0]       idx;
  logic signed [VAL_W-1:0] wval;
  req_t                   req;
  sel_t                   sel;
  logic                   accept, bad;

  assign idx    = s_axis_tdata[IDX_W-1:0];
  assign wval   = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
  assign req    = req_t'(s_axis_tuser[1:0]);
  assign sel    = sel_t'(s_axis_tuser[3:2]);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (sel)
      SEL_IMAGE:  bad = (ISW'(idx) >= img_size) || (32'(idx) >= 32'(IMG_DEPTH));
      SEL_KERNEL: bad = (KSW'(idx) >= ker_size) || (32'(idx) >= 32'(KER_DEPTH));
      SEL_OUTPUT: bad = (OSW'(idx) >= out_size) || (32'(idx) >= 32'(OUT_DEPTH));
      default:    bad = 1'b1;
    endcase
  end

  // state
  state_t state;
  sel_t   sel_q;
  logic   sat;
  logic   step, last;
  logic   empty;

  assign empty = (r_eff == '0) || (c_eff == '0) || (ch_eff == '0) || (k_eff == '0) ||
                 (kr_eff == '0) || (kc_eff == '0);

  // loop counter chain: channel, kernel col, kernel row, kernel, col, row
  logic [CW-1:0] cv  [NCELL];
  logic [CW-1:0] lim [NCELL];
  logic [NCELL:0] cy;
  cell_ctl_t     ctl [NCELL];

  assign lim[0] = ch_eff;
  assign lim[1] = kc_eff;
  assign lim[2] = kr_eff;
  assign lim[3] = k_eff;
  assign lim[4] = c_eff;
  assign lim[5] = r_eff;
  assign cy[0]  = step;
  assign last   = cy[NCELL];

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    assign ctl[g].clr = (state == S_IDLE);
    assign ctl[g].inc = cy[g];
    cmm_ctr_cell #(.W(CW)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl[g]),
      .lim   (lim[g]),
      .val   (cv[g]),
      .carry (cy[g+1])
    );
  end

  // window position
  logic signed [CW+1:0] ii, jj;
  logic                 in_win;

  assign ii = $signed({2'b00, cv[5]}) + $signed({2'b00, cv[2]}) - $signed({2'b00, hr});
  assign jj = $signed({2'b00, cv[4]}) + $signed({2'b00, cv[1]}) - $signed({2'b00, hc});
  assign in_win = (ii >= 0) && (ii < $signed({2'b00, r_eff})) &&
                  (jj >= 0) && (jj < $signed({2'b00, c_eff}));

  // address generation
  logic [OAW-1:0] t_o, o_addr;
  logic [IAW-1:0] t_m, m_addr;
  logic [KAW-1:0] t_w, t_w2, w_addr;

  // stores
  logic signed [VAL_W-1:0] image_store  [IMG_DEPTH];
  logic signed [VAL_W-1:0] kernel_store [KER_DEPTH];
  logic signed [VAL_W-1:0] output_store [OUT_DEPTH];
  logic signed [VAL_W-1:0] img_q, ker_q, out_q;
  logic signed [VAL_W-1:0] mac_a, mac_b, mac_acc, mac_sum;
  logic                    mac_ovf;
  logic                    host_wr;
  logic                    img_we, ker_we, out_we;
  logic [IAW-1:0]          img_wa;
  logic [KAW-1:0]          ker_wa;
  logic [OAW-1:0]          out_wa;
  logic signed [VAL_W-1:0] img_wd, ker_wd, out_wd;

  assign host_wr = accept && (req == REQ_WRITE) && !bad;

  always_comb begin
    img_we = host_wr && (sel == SEL_IMAGE);
    ker_we = host_wr && (sel == SEL_KERNEL);
    out_we = host_wr && (sel == SEL_OUTPUT);
    img_wa = IAW'(idx);
    ker_wa = KAW'(idx);
    out_wa = OAW'(idx);
    img_wd = wval;
    ker_wd = wval;
    out_wd = wval;
    if (state == S_ACC) begin
      img_we = (mac_mode == MODE_IGRAD);
      ker_we = (mac_mode == MODE_KGRAD);
      out_we = (mac_mode == MODE_FWD);
      img_wa = m_addr;
      ker_wa = w_addr;
      out_wa = o_addr;
      img_wd = mac_sum;
      ker_wd = mac_sum;
      out_wd = mac_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (img_we) image_store[img_wa] <= img_wd;
    img_q <= image_store[m_addr];
  end

  always_ff @(posedge clk) begin
    if (ker_we) kernel_store[ker_wa] <= ker_wd;
    ker_q <= kernel_store[w_addr];
  end

  always_ff @(posedge clk) begin
    if (out_we) output_store[out_wa] <= out_wd;
    out_q <= output_store[o_addr];
  end

  always_comb begin
    case (mac_mode)
      MODE_FWD: begin
        mac_a = img_q; mac_b = ker_q; mac_acc = out_q;
      end
      MODE_IGRAD: begin
        mac_a = out_q; mac_b = ker_q; mac_acc = img_q;
      end
      default: begin
        mac_a = out_q; mac_b = img_q; mac_acc = ker_q;
      end
    endcase
  end

  cmm_mac u_mac (
    .clk (clk),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac_acc),
    .sum (mac_sum),
    .ovf (mac_ovf)
  );

  assign step = ((state == S_P0) && !in_win) || (state == S_ACC);

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        o_addr <= OAW'(idx);
        m_addr <= IAW'(idx);
        w_addr <= KAW'(idx);
      end
      S_P0: begin
        t_o <= OAW'(cv[5]) * OAW'(c_eff) + OAW'(cv[4]);
        t_m <= IAW'(ii[CW-1:0]) * IAW'(c_eff) + IAW'(jj[CW-1:0]);
        t_w <= KAW'(cv[3]) * KAW'(kr_eff) + KAW'(cv[2]);
      end
      S_P1: begin
        o_addr <= t_o * OAW'(k_eff) + OAW'(cv[3]);
        m_addr <= t_m * IAW'(ch_eff) + IAW'(cv[0]);
        t_w2   <= t_w * KAW'(kc_eff) + KAW'(cv[1]);
      end
      S_P2: begin
        w_addr <= t_w2 * KAW'(ch_eff) + KAW'(cv[0]);
      end
      default: ;
    endcase
  end

  // output register
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_rv;
  logic                    out_st, out_sat;

  assign s_axis_tready = (state == S_IDLE) && !out_valid && (cfg_wait == '0);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(M_DATA_W-VAL_W-2){1'b0}}, out_sat, out_st, out_rv};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sat       <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          sel_q <= sel;
          if (accept) begin
            out_rv  <= '0;
            out_sat <= 1'b0;
            case (req)
              REQ_WRITE: begin
                out_st    <= bad;
                out_valid <= 1'b1;
              end
              REQ_READ: begin
                if (bad) begin
                  out_st    <= 1'b1;
                  out_valid <= 1'b1;
                end else begin
                  state <= S_HRD;
                end
              end
              REQ_RUN: begin
                if (mac_mode == MODE_NONE) begin
                  out_st    <= 1'b1;
                  out_valid <= 1'b1;
                end else if (empty) begin
                  out_st    <= 1'b0;
                  out_valid <= 1'b1;
                end else begin
                  sat   <= 1'b0;
                  state <= S_P0;
                end
              end
              default: begin
                out_st    <= 1'b1;
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_HRD: state <= S_HOUT;
        S_HOUT: begin
          case (sel_q)
            SEL_IMAGE:  out_rv <= img_q;
            SEL_KERNEL: out_rv <= ker_q;
            default:    out_rv <= out_q;
          endcase
          out_st    <= 1'b0;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_P0: begin
          if (!in_win) begin
            if (last) begin
              out_st    <= 1'b0;
              out_sat   <= sat;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            state <= S_P1;
          end
        end
        S_P1: state <= S_P2;
        S_P2: state <= S_RD;
        S_RD: state <= S_MUL;
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (last) begin
            out_st    <= 1'b0;
            out_sat   <= sat || mac_ovf;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            sat   <= sat || mac_ovf;
            state <= S_P0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_no_beat: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready)
    else $error("beat taken while busy");

  a_fwd_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && mac_mode == MODE_FWD) |-> (OSW'(o_addr) < out_size))
    else $error("output address outside tensor");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_IDLE || state == S_HOUT ||
                                   state == S_P0 || state == S_ACC))
    else $error("result from unexpected state");

endmodule
